[rtl/kthf_pkg.sv]
// Package: shared types, constants and state codes of the keypoint hysteresis filter.
package kthf_pkg;

    localparam int NFRAMES_DEF = 16;
    localparam int NPOINTS_DEF = 1024;

    localparam int CFG_DW = 16;
    localparam int CFG_AW = 1;
    localparam int LIM_W  = 38;

    localparam logic [CFG_AW-1:0] REG_FRAMES_IN_USE   = 1'd0;
    localparam logic [CFG_AW-1:0] REG_SCORE_THRESHOLD = 1'd1;

    localparam logic [4:0]         FRAMES_RESET = 5'd8;
    localparam logic signed [15:0] THRESH_RESET = 16'sd0;

    // 8.5 pixels in 1/16 pixel, squared
    localparam logic [32:0] PAST_D2_LIM = 33'd18496;
    // 3.5 squared as 49/4; with the 10-bit shift in the match unit, 49/1024 = 49/4 / 256 for Q8.8 scale squared
    localparam logic [5:0]  LATER_MUL   = 6'd49;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic              first_of_frame;
        logic              has_point;
        logic [15:0]       pos_x;
        logic [15:0]       pos_y;
        logic [15:0]       pt_scale;
        logic signed [15:0] pt_score;
        logic [3:0]        query_frame;
        logic [9:0]        query_point;
    } t_in_item;

    typedef struct packed {
        logic              decision;
        logic              in_range;
        logic [15:0]       out_x;
        logic [15:0]       out_y;
        logic [15:0]       out_scale;
        logic signed [15:0] out_score;
        logic [10:0]       frame_count;
    } t_out_item;

    typedef struct packed {
        logic [15:0] score;
        logic [15:0] scale;
        logic [15:0] y;
        logic [15:0] x;
    } t_entry;

    typedef struct packed {
        logic valid;
        logic flush;
        logic past;
    } t_match_ctl;

    typedef struct packed {
        logic hit;
        logic busy;
    } t_match_sts;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADV,
        S_ADD,
        S_SCAN,
        S_STORE,
        S_QCHK,
        S_QWAIT,
        S_LIM1,
        S_LIM2,
        S_DONE
    } t_state;

endpackage

[rtl/kthf_ram.sv]
// Generic single-clock RAM: one write port, one read port with registered read data.
module kthf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/kthf_match.sv]
// Distance match unit: squares in one stage, then sum and compare against the active limit.
module kthf_match (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  kthf_pkg::t_match_ctl       i_ctl,
    input  kthf_pkg::t_entry           i_entry,
    input  logic [15:0]                i_ref_x,
    input  logic [15:0]                i_ref_y,
    input  logic [kthf_pkg::LIM_W-1:0] i_lim,
    output kthf_pkg::t_match_sts       o_sts
);

    logic        r_v1;
    logic        r_past;
    logic [31:0] r_sqx;
    logic [31:0] r_sqy;
    logic [15:0] dx;
    logic [15:0] dy;
    logic [32:0] d2;
    logic        hit;

    // absolute differences
    always_comb begin
        dx = (i_ref_x > i_entry.x) ? (i_ref_x - i_entry.x) : (i_entry.x - i_ref_x);
        dy = (i_ref_y > i_entry.y) ? (i_ref_y - i_entry.y) : (i_entry.y - i_ref_y);
    end

    // register the squares and the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.valid & ~i_ctl.flush;
        end
        r_past <= i_ctl.past;
        r_sqx  <= 32'(dx) * 32'(dx);
        r_sqy  <= 32'(dy) * 32'(dy);
    end

    // sum and compare against past radius or later radius
    always_comb begin
        d2 = 33'(r_sqx) + 33'(r_sqy);
        if (r_past) begin
            hit = d2 < kthf_pkg::PAST_D2_LIM;
        end else begin
            hit = {d2, 10'b0} < 43'(i_lim);
        end
    end

    assign o_sts.hit  = r_v1 & ~i_ctl.flush & hit;
    assign o_sts.busy = r_v1 & ~i_ctl.flush;

endmodule

[rtl/keypoint_temporal_hysteresis_filter_top.sv]
// Top level of the keypoint temporal hysteresis filter: control sequencer, counts and point store.
// Sequence: a frame marker advances the newest slot modulo the ring and empties it (one more step
// per wrap of the slot when the ring has shrunk); an add above threshold is stored at once; an add
// tested against the past and a query walk the stored points one read at a time through the
// single read port of the point store.
// Throughput: one item at a time; a new item is taken while a finished result waits.
// Reset clears the slot counts, the newest slot and the input count; the store is not cleared.
module keypoint_temporal_hysteresis_filter_top #(
    parameter int NFRAMES = kthf_pkg::NFRAMES_DEF,
    parameter int NPOINTS = kthf_pkg::NPOINTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [kthf_pkg::CFG_AW-1:0] i_cfg_idx,
    input  logic [kthf_pkg::CFG_DW-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  kthf_pkg::t_in_item          i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output kthf_pkg::t_out_item         o_out_item
);

    localparam int SW    = $clog2(NFRAMES);
    localparam int FW0   = $clog2(NFRAMES + 1);
    localparam int FW    = (FW0 > 5) ? FW0 : 5;
    localparam int CNW   = $clog2(NPOINTS + 1);
    localparam int DEPTH = NFRAMES * NPOINTS;
    localparam int AW    = $clog2(DEPTH);

    kthf_pkg::t_state r_state, n_state;

    logic [4:0]          r_frames;
    logic signed [15:0]  r_thr;
    logic [FW-1:0]       ring;

    logic [SW-1:0]       r_newest, n_newest;
    logic [CNW-1:0]      r_counts [NFRAMES];
    logic [CNW-1:0]      r_inputs, n_inputs;
    kthf_pkg::t_in_item  r_item, n_item;
    logic [FW-1:0]       r_tmp, n_tmp;
    logic [SW-1:0]       r_slot, n_slot;
    logic [CNW-1:0]      r_idx, n_idx;
    logic [FW-1:0]       r_k, n_k;
    logic                r_iss, n_iss;
    logic                r_p1, n_p1;
    logic                r_past, n_past;
    logic                r_qin, n_qin;
    logic                r_dec, n_dec;
    logic                r_ok, n_ok;
    logic [31:0]         r_sq, n_sq;
    logic [kthf_pkg::LIM_W-1:0] r_lim, n_lim;
    kthf_pkg::t_entry    r_ent, n_ent;
    logic [15:0]         r_ref_x, n_ref_x;
    logic [15:0]         r_ref_y, n_ref_y;
    logic                r_out_valid, n_out_valid;
    kthf_pkg::t_out_item r_out, n_out;

    logic                cnt_we;
    logic [SW-1:0]       cnt_waddr;
    logic [CNW-1:0]      cnt_wdata;
    logic [SW-1:0]       cnt_sel;
    logic [CNW-1:0]      cnt_rd;
    logic [CNW-1:0]      cnt_cur;
    logic                issue;
    logic                ram_we;
    logic                ram_re;
    logic [AW-1:0]       ram_waddr;
    logic [AW-1:0]       ram_raddr;
    kthf_pkg::t_entry    ram_wdata;
    kthf_pkg::t_entry    ram_rdata;
    kthf_pkg::t_match_ctl m_ctl;
    kthf_pkg::t_match_sts m_sts;
    logic [SW-1:0]       qslot;
    logic                accept;

    // effective ring size
    always_comb begin
        if (r_frames == 5'd0) begin
            ring = FW'(1);
        end else if (32'(r_frames) > 32'(NFRAMES)) begin
            ring = FW'(NFRAMES);
        end else begin
            ring = FW'(r_frames);
        end
    end

    assign qslot      = SW'(r_item.query_frame);
    assign o_in_ready = (r_state == kthf_pkg::S_IDLE);
    assign accept     = i_in_valid & o_in_ready;

    // slot count read port
    always_comb begin
        if (r_state == kthf_pkg::S_SCAN) begin
            cnt_sel = r_slot;
        end else if (r_item.cmd == kthf_pkg::CMD_QUERY) begin
            cnt_sel = qslot;
        end else begin
            cnt_sel = r_newest;
        end
        cnt_rd  = r_counts[cnt_sel];
        cnt_cur = (r_past && (r_slot == r_newest)) ? '0 : cnt_rd;
        issue   = (r_state == kthf_pkg::S_SCAN) && r_iss && (r_idx < cnt_cur);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            kthf_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_in_item.cmd == kthf_pkg::CMD_QUERY) begin
                        n_state = kthf_pkg::S_QCHK;
                    end else if (i_in_item.first_of_frame) begin
                        n_state = kthf_pkg::S_ADV;
                    end else begin
                        n_state = kthf_pkg::S_ADD;
                    end
                end
            end
            kthf_pkg::S_ADV: begin
                if (r_tmp < ring) begin
                    n_state = kthf_pkg::S_ADD;
                end
            end
            kthf_pkg::S_ADD: begin
                if (!r_item.has_point || (r_inputs >= CNW'(NPOINTS))) begin
                    n_state = kthf_pkg::S_DONE;
                end else if ($signed(r_item.pt_score) > r_thr) begin
                    n_state = kthf_pkg::S_STORE;
                end else begin
                    n_state = kthf_pkg::S_SCAN;
                end
            end
            kthf_pkg::S_SCAN: begin
                if (m_sts.hit) begin
                    n_state = r_past ? kthf_pkg::S_STORE : kthf_pkg::S_DONE;
                end else if (!r_iss && !r_p1 && !m_sts.busy) begin
                    n_state = kthf_pkg::S_DONE;
                end
            end
            kthf_pkg::S_STORE: n_state = kthf_pkg::S_DONE;
            kthf_pkg::S_QCHK: begin
                if ((32'(r_item.query_frame) < 32'(ring)) &&
                    (32'(r_item.query_point) < 32'(cnt_rd))) begin
                    n_state = kthf_pkg::S_QWAIT;
                end else begin
                    n_state = kthf_pkg::S_DONE;
                end
            end
            kthf_pkg::S_QWAIT: begin
                n_state = (qslot == r_newest) ? kthf_pkg::S_DONE : kthf_pkg::S_LIM1;
            end
            kthf_pkg::S_LIM1: n_state = kthf_pkg::S_LIM2;
            kthf_pkg::S_LIM2: n_state = kthf_pkg::S_SCAN;
            kthf_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = kthf_pkg::S_IDLE;
                end
            end
            default: n_state = kthf_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs of each state
    always_comb begin
        n_newest    = r_newest;
        n_inputs    = r_inputs;
        n_item      = r_item;
        n_tmp       = r_tmp;
        n_slot      = r_slot;
        n_idx       = r_idx;
        n_k         = r_k;
        n_iss       = r_iss;
        n_p1        = issue;
        n_past      = r_past;
        n_qin       = r_qin;
        n_dec       = r_dec;
        n_ok        = r_ok;
        n_sq        = r_sq;
        n_lim       = r_lim;
        n_ent       = r_ent;
        n_ref_x     = r_ref_x;
        n_ref_y     = r_ref_y;
        n_out       = r_out;
        n_out_valid = r_out_valid & ~i_out_ready;
        cnt_we      = 1'b0;
        cnt_waddr   = r_newest;
        cnt_wdata   = '0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = AW'(r_newest) * AW'(NPOINTS) + AW'(cnt_rd);
        ram_wdata   = {r_item.pt_score, r_item.pt_scale, r_item.pos_y, r_item.pos_x};
        ram_raddr   = AW'(r_slot) * AW'(NPOINTS) + AW'(r_idx);
        case (r_state)
            kthf_pkg::S_IDLE: begin
                if (accept) begin
                    n_item = i_in_item;
                    n_tmp  = FW'(r_newest) + FW'(1);
                    n_dec  = 1'b0;
                    n_ok   = 1'b0;
                    n_past = 1'b0;
                    n_iss  = 1'b0;
                end
            end
            kthf_pkg::S_ADV: begin
                // reduce the advanced slot modulo the ring, then empty it
                if (r_tmp >= ring) begin
                    n_tmp = r_tmp - ring;
                end else begin
                    n_newest  = SW'(r_tmp);
                    n_inputs  = '0;
                    cnt_we    = 1'b1;
                    cnt_waddr = SW'(r_tmp);
                    cnt_wdata = '0;
                end
            end
            kthf_pkg::S_ADD: begin
                n_ok = 1'b1;
                if (r_item.has_point) begin
                    if (r_inputs >= CNW'(NPOINTS)) begin
                        n_ok = 1'b0;
                    end else begin
                        n_inputs = r_inputs + CNW'(1);
                        n_slot   = '0;
                        n_idx    = '0;
                        n_iss    = 1'b1;
                        n_past   = 1'b1;
                        n_ref_x  = r_item.pos_x;
                        n_ref_y  = r_item.pos_y;
                    end
                end
            end
            kthf_pkg::S_SCAN: begin
                if (issue) begin
                    ram_re = 1'b1;
                    n_idx  = r_idx + CNW'(1);
                end else if (r_iss) begin
                    // end of a slot: advance or finish the walk
                    n_idx = '0;
                    if (r_past) begin
                        if ((FW'(r_slot) + FW'(1)) >= ring) begin
                            n_iss = 1'b0;
                        end else begin
                            n_slot = r_slot + SW'(1);
                        end
                    end else begin
                        if ((r_slot == r_newest) || ((r_k + FW'(1)) >= ring)) begin
                            n_iss = 1'b0;
                        end else begin
                            n_k    = r_k + FW'(1);
                            n_slot = ((FW'(r_slot) + FW'(1)) >= ring) ? '0 : r_slot + SW'(1);
                        end
                    end
                end
                if (m_sts.hit) begin
                    n_iss = 1'b0;
                    n_dec = 1'b0;
                end else if (!r_iss && !r_p1 && !m_sts.busy) begin
                    n_dec = ~r_past;
                end
            end
            kthf_pkg::S_STORE: begin
                ram_we    = 1'b1;
                cnt_we    = 1'b1;
                cnt_waddr = r_newest;
                cnt_wdata = cnt_rd + CNW'(1);
                n_dec     = 1'b1;
            end
            kthf_pkg::S_QCHK: begin
                n_qin     = 32'(r_item.query_frame) < 32'(ring);
                ram_raddr = AW'(qslot) * AW'(NPOINTS) + AW'(r_item.query_point);
                ram_re    = 1'b1;
            end
            kthf_pkg::S_QWAIT: begin
                n_ent   = ram_rdata;
                n_ok    = 1'b1;
                n_ref_x = ram_rdata.x;
                n_ref_y = ram_rdata.y;
                n_dec   = (qslot == r_newest);
            end
            kthf_pkg::S_LIM1: begin
                n_sq = 32'(r_ent.scale) * 32'(r_ent.scale);
            end
            kthf_pkg::S_LIM2: begin
                n_lim  = kthf_pkg::LIM_W'(r_sq) * kthf_pkg::LIM_W'(kthf_pkg::LATER_MUL);
                n_slot = ((FW'(qslot) + FW'(1)) >= ring) ? '0 : qslot + SW'(1);
                n_k    = '0;
                n_idx  = '0;
                n_iss  = 1'b1;
                n_past = 1'b0;
            end
            kthf_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid       = 1'b1;
                    n_out.decision    = r_dec;
                    n_out.in_range    = r_ok;
                    if ((r_item.cmd == kthf_pkg::CMD_QUERY) && r_ok) begin
                        n_out.out_x     = r_ent.x;
                        n_out.out_y     = r_ent.y;
                        n_out.out_scale = r_ent.scale;
                        n_out.out_score = $signed(r_ent.score);
                    end else begin
                        n_out.out_x     = '0;
                        n_out.out_y     = '0;
                        n_out.out_scale = '0;
                        n_out.out_score = '0;
                    end
                    if ((r_item.cmd == kthf_pkg::CMD_QUERY) && !r_qin) begin
                        n_out.frame_count = '0;
                    end else begin
                        n_out.frame_count = 11'(cnt_rd);
                    end
                end
            end
            default: begin
                n_iss = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kthf_pkg::S_IDLE;
            r_newest    <= '0;
            r_inputs    <= '0;
            r_iss       <= 1'b0;
            r_p1        <= 1'b0;
            r_out_valid <= 1'b0;
            r_frames    <= kthf_pkg::FRAMES_RESET;
            r_thr       <= kthf_pkg::THRESH_RESET;
        end else begin
            r_state     <= n_state;
            r_newest    <= n_newest;
            r_inputs    <= n_inputs;
            r_iss       <= n_iss;
            r_p1        <= n_p1;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    kthf_pkg::REG_FRAMES_IN_USE:   r_frames <= i_cfg_data[4:0];
                    kthf_pkg::REG_SCORE_THRESHOLD: r_thr    <= $signed(i_cfg_data);
                    default: ;
                endcase
            end
        end
    end

    // slot counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NFRAMES; i++) begin
                r_counts[i] <= '0;
            end
        end else if (cnt_we) begin
            r_counts[cnt_waddr] <= cnt_wdata;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_item  <= n_item;
        r_tmp   <= n_tmp;
        r_slot  <= n_slot;
        r_idx   <= n_idx;
        r_k     <= n_k;
        r_past  <= n_past;
        r_qin   <= n_qin;
        r_dec   <= n_dec;
        r_ok    <= n_ok;
        r_sq    <= n_sq;
        r_lim   <= n_lim;
        r_ent   <= n_ent;
        r_ref_x <= n_ref_x;
        r_ref_y <= n_ref_y;
        r_out   <= n_out;
    end

    kthf_ram #(
        .WIDTH ($bits(kthf_pkg::t_entry)),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign m_ctl.valid = r_p1 & (r_state == kthf_pkg::S_SCAN);
    assign m_ctl.flush = (r_state != kthf_pkg::S_SCAN);
    assign m_ctl.past  = r_past;

    kthf_match u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (m_ctl),
        .i_entry (ram_rdata),
        .i_ref_x (r_ref_x),
        .i_ref_y (r_ref_y),
        .i_lim   (r_lim),
        .o_sts   (m_sts)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

[rtl/kthf_checker.sv]
// Port checker for the keypoint hysteresis filter, bound to the top level.
module kthf_checker #(
    parameter int NPOINTS = kthf_pkg::NPOINTS_DEF
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input kthf_pkg::t_out_item         o_out_item
);

    // a stalled result transaction stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a refused item is never a positive decision
    a_range_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.in_range |-> !o_out_item.decision)
        else $error("decision set on out-of-range transaction");

    // a slot never holds more points than it has room for
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_out_item.frame_count) <= 32'(NPOINTS)))
        else $error("frame count above capacity");

    // an accepted transaction makes the input busy on the next cycle
    a_one_per_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("busy flag missing after accepted transaction");

endmodule

bind keypoint_temporal_hysteresis_filter_top kthf_checker #(.NPOINTS(NPOINTS)) u_chk (.*);
